### hdl/esd_pkg.sv
// ----------------------------------------------------------------------------
// esd_pkg: shared types and constants for the expression selector
// Prototype and idle tables, axis weights, register indexes and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package esd_pkg;

    localparam int AXES        = 6;
    localparam int TABLE_ROWS  = 10;
    localparam int AXW         = 16;
    localparam int EXW         = 4;
    localparam int WGTW        = 8;
    localparam int CFG_IDXW    = 8;
    localparam int CFG_DATAW   = 16;

    localparam int DEF_NUM_PROTOTYPES = 10;
    localparam int DEF_AXIS_FRAC_BITS = 14;
    localparam int DEF_TIME_BITS      = 32;

    localparam logic [CFG_IDXW-1:0] CFG_DWELL  = 8'd0;
    localparam logic [CFG_IDXW-1:0] CFG_MARGIN = 8'd1;

    localparam logic [15:0] DWELL_RESET  = 16'd650;
    localparam logic [15:0] MARGIN_RESET = 16'd1638;

    // Prototypes, idle vector and weights in hundredths
    localparam int PROTO_H [TABLE_ROWS][AXES] = '{
        '{  0, -20,  10,  65,   5,  0},
        '{ 65,  35,  20,  65,  65, 10},
        '{ 15,  25,  15,  75,  20,  5},
        '{ 90,  65,  20,  70,  80, 25},
        '{-20,  45, -55,  10,  25, 20},
        '{-15,   0,  55,  90, -10,  0},
        '{-55,  45, -65, -15,   5, 20},
        '{-65,  55,  60,  70, -55,  0},
        '{ 45, -25,   0,  60,  75,  0},
        '{ 95,  95,  35,  65,  70, 55}
    };
    localparam int IDLE_H [AXES] = '{35, -35, 5, 65, 60, 0};
    localparam int WEIGHT_H [AXES] = '{140, 100, 65, 35, 85, 75};

    // Hundredths to axis units, rounded half away from zero
    function automatic int to_axis(input int h, input int frac);
        longint mag;
        longint v;
        mag = (h < 0) ? -longint'(h) : longint'(h);
        v = (mag * (longint'(1) << frac) * 2 + 100) / 200;
        return (h < 0) ? int'(-v) : int'(v);
    endfunction

    typedef struct packed {
        logic capture;
        logic perform;
        logic blend;
        logic search_start;
        logic decide;
        logic init_commit;
        logic out_load;
    } esd_cmd_t;

    typedef struct packed {
        logic blend_last;
        logic search_done;
    } esd_status_t;

endpackage

### hdl/esd_datapath.sv
// ----------------------------------------------------------------------------
// esd_datapath: affect vector, blend unit and distance search
// Holds the state and configuration, blends one axis per cycle and runs a
// three-stage square, weight and accumulate pipeline over prototype axes.
// ----------------------------------------------------------------------------
module esd_datapath import esd_pkg::*; #(
    parameter int NUM_PROTOTYPES = DEF_NUM_PROTOTYPES,
    parameter int AXIS_FRAC_BITS = DEF_AXIS_FRAC_BITS,
    parameter int TIME_BITS      = DEF_TIME_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  esd_cmd_t              cmd,
    output esd_status_t           status,
    input  logic                  cfg_we,
    input  logic [CFG_IDXW-1:0]   cfg_index,
    input  logic [CFG_DATAW-1:0]  cfg_data,
    input  logic                  in_mode,
    input  logic signed [AXW-1:0] axis_in [AXES],
    input  logic [15:0]           in_fraction,
    input  logic [EXW-1:0]        in_expression,
    input  logic [31:0]           in_time,
    output logic [EXW-1:0]        out_expression,
    output logic signed [AXW-1:0] axis_out [AXES]
);

    localparam int NP    = (NUM_PROTOTYPES < TABLE_ROWS) ? NUM_PROTOTYPES : TABLE_ROWS;
    localparam int PW    = AXIS_FRAC_BITS + 2;
    localparam int DW    = ((PW > AXW) ? PW : AXW) + 1;
    localparam int SQW   = 2 * DW;
    localparam int TW    = SQW + WGTW;
    localparam int DISTW = SQW + 11;
    localparam int MW    = DISTW + 1;
    localparam int BPW   = AXW + 18;
    localparam logic [EXW-1:0] LAST_ROW = EXW'(NP - 1);
    localparam logic [2:0]     LAST_AX  = 3'(AXES - 1);

    // Prototype table in axis units, fixed at elaboration
    logic signed [PW-1:0] proto_tab [TABLE_ROWS][AXES];
    for (genvar r = 0; r < TABLE_ROWS; r++) begin : g_row
        for (genvar a = 0; a < AXES; a++) begin : g_ax
            assign proto_tab[r][a] = PW'(to_axis(PROTO_H[r][a], AXIS_FRAC_BITS));
        end
    end

    // State and configuration
    logic signed [AXW-1:0] axis_reg [AXES];
    logic [EXW-1:0]        shown_reg, cand_reg;
    logic [TIME_BITS-1:0]  start_reg;
    logic [15:0]           dwell_reg, margin_reg;

    // Captured request
    logic signed [AXW-1:0] tgt_reg [AXES];
    logic [15:0]           frac_reg;
    logic [TIME_BITS-1:0]  now_reg;
    logic [2:0]            ax_reg;

    // Search pipeline
    logic [EXW-1:0]  row_reg;
    logic [2:0]      sax_reg;
    logic            iss_reg;
    logic            s1_v_reg, s1_last_reg, s2_v_reg, s2_last_reg, done_reg;
    logic [EXW-1:0]  s1_row_reg, s2_row_reg;
    logic [SQW-1:0]  sq_reg;
    logic [WGTW-1:0] w_reg;
    logic [TW-1:0]   term_reg;
    logic [DISTW-1:0] acc_reg, best_reg, shown_d_reg;
    logic [EXW-1:0]  best_idx_reg;

    logic [63:0]          time_ext;
    logic [TIME_BITS-1:0] now_w;
    assign time_ext = {32'd0, in_time};
    assign now_w    = time_ext[TIME_BITS-1:0];

    // Blend of the selected axis
    logic signed [AXW:0]   diff;
    logic signed [BPW-1:0] prod;
    logic signed [BPW-1:0] step;
    always_comb begin
        diff = (AXW+1)'(tgt_reg[ax_reg]) - (AXW+1)'(axis_reg[ax_reg]);
        prod = BPW'(diff) * $signed({{(BPW-17){1'b0}}, frac_reg, 1'b0}) >>> 1;
        step = (prod + BPW'(32768)) >>> 16;
    end

    // First search stage: difference and square
    logic signed [DW-1:0]  dist_d;
    logic signed [SQW-1:0] dist_sq;
    always_comb begin
        dist_d  = DW'(axis_reg[sax_reg]) - DW'(proto_tab[row_reg][sax_reg]);
        dist_sq = SQW'(dist_d) * SQW'(dist_d);
    end

    // Accumulated distance at the end of a row
    logic [DISTW-1:0] full_d;
    assign full_d = acc_reg + DISTW'(term_reg);

    // Switch decision
    logic                 cand_new;
    logic [TIME_BITS-1:0] elapsed;
    logic [MW-1:0]        margin_scaled;
    logic                 do_switch;
    always_comb begin
        cand_new      = (best_idx_reg != cand_reg);
        elapsed       = cand_new ? '0 : (now_reg - start_reg);
        margin_scaled = (MW'(margin_reg) * MW'(100)) << AXIS_FRAC_BITS;
        do_switch     = (best_idx_reg != shown_reg) &&
                        (elapsed >= TIME_BITS'(dwell_reg)) &&
                        ((MW'(best_reg) + margin_scaled) < MW'(shown_d_reg));
    end

    logic perform_ok;
    assign perform_ok = (in_expression < EXW'(NP));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < AXES; a++) begin
                axis_reg[a] <= AXW'(to_axis(IDLE_H[a], AXIS_FRAC_BITS));
            end
            shown_reg  <= '0;
            cand_reg   <= '0;
            start_reg  <= '0;
            dwell_reg  <= DWELL_RESET;
            margin_reg <= MARGIN_RESET;
            ax_reg     <= '0;
            iss_reg    <= 1'b0;
            s1_v_reg   <= 1'b0;
            s2_v_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            // configuration writes
            if (cfg_we && cfg_index == CFG_DWELL) begin
                dwell_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_MARGIN) begin
                margin_reg <= cfg_data;
            end

            // request capture and perform load
            if (cmd.capture) begin
                tgt_reg  <= axis_in;
                frac_reg <= in_fraction;
                now_reg  <= now_w;
                ax_reg   <= '0;
            end
            if (cmd.perform && in_mode && perform_ok) begin
                axis_reg  <= axis_in;
                shown_reg <= in_expression;
                cand_reg  <= in_expression;
                start_reg <= now_w;
            end

            // blend one axis
            if (cmd.blend) begin
                axis_reg[ax_reg] <= axis_reg[ax_reg] + AXW'(step);
                ax_reg           <= ax_reg + 3'd1;
            end

            // search issue counters
            if (cmd.search_start) begin
                row_reg <= '0;
                sax_reg <= '0;
                iss_reg <= 1'b1;
                acc_reg <= '0;
            end else if (iss_reg) begin
                if (sax_reg == LAST_AX) begin
                    sax_reg <= '0;
                    if (row_reg == LAST_ROW) begin
                        iss_reg <= 1'b0;
                    end else begin
                        row_reg <= row_reg + 1'b1;
                    end
                end else begin
                    sax_reg <= sax_reg + 3'd1;
                end
            end

            // stage 1: square
            s1_v_reg    <= iss_reg;
            s1_last_reg <= (sax_reg == LAST_AX);
            s1_row_reg  <= row_reg;
            sq_reg      <= dist_sq;
            w_reg       <= WGTW'(WEIGHT_H[sax_reg]);

            // stage 2: weight
            s2_v_reg    <= s1_v_reg;
            s2_last_reg <= s1_last_reg;
            s2_row_reg  <= s1_row_reg;
            term_reg    <= TW'(sq_reg) * TW'(w_reg);

            // stage 3: accumulate and keep the nearest
            done_reg <= s2_v_reg && s2_last_reg && (s2_row_reg == LAST_ROW);
            if (s2_v_reg && !cmd.search_start) begin
                if (s2_last_reg) begin
                    acc_reg <= '0;
                    if (s2_row_reg == '0 || full_d < best_reg) begin
                        best_reg     <= full_d;
                        best_idx_reg <= s2_row_reg;
                    end
                    if (s2_row_reg == shown_reg) begin
                        shown_d_reg <= full_d;
                    end
                end else begin
                    acc_reg <= full_d;
                end
            end

            // commit after a tick or after the reset search
            if (cmd.decide) begin
                if (cand_new) begin
                    cand_reg  <= best_idx_reg;
                    start_reg <= now_reg;
                end
                if (do_switch) begin
                    shown_reg <= best_idx_reg;
                end
            end
            if (cmd.init_commit) begin
                shown_reg <= best_idx_reg;
                cand_reg  <= best_idx_reg;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_expression <= shown_reg;
            axis_out       <= axis_reg;
        end
    end

    assign status.blend_last  = (ax_reg == LAST_AX);
    assign status.search_done = done_reg;

endmodule

### hdl/esd_ctrl.sv
// ----------------------------------------------------------------------------
// esd_ctrl: sequencing controller
// Runs the reset search, then per tick request the blend, search and decision
// steps, loads a perform request directly, and holds the result valid flag.
// ----------------------------------------------------------------------------
module esd_ctrl import esd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    output logic        m_valid,
    input  logic        m_ready,
    output esd_cmd_t    cmd,
    input  esd_status_t status
);

    typedef enum logic [2:0] {
        ST_INIT, ST_INIT_WAIT, ST_IDLE, ST_BLEND, ST_SEARCH, ST_DECIDE, ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept, out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        case (state_reg)
            ST_INIT: begin
                cmd.search_start = 1'b1;
                state_next       = ST_INIT_WAIT;
            end
            ST_INIT_WAIT: begin
                if (status.search_done) begin
                    cmd.init_commit = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    cmd.capture = 1'b1;
                    cmd.perform = 1'b1;
                    state_next  = s_mode ? ST_FINISH : ST_BLEND;
                end
            end
            ST_BLEND: begin
                cmd.blend = 1'b1;
                if (status.blend_last) begin
                    cmd.search_start = 1'b1;
                    state_next       = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (status.search_done) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    // State and valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

### hdl/expression_select_with_dwell.sv
// Sequence: after acceptance a tick request blends one axis per cycle, then runs
// the shared square/weight pipeline over every prototype axis; a perform request
// with a valid expression loads its vector and expression directly. One request
// is taken at a time; a result waiting on m_ready does not block acceptance of
// the next request, though it holds that request's result back.
// Reset: synchronous active low; a search sets the shown expression first.
// ----------------------------------------------------------------------------
// expression_select_with_dwell: affect blend with dwell-gated expression
// Blends a six-axis affect vector toward a target, finds the nearest
// prototype and switches the shown expression after dwell and margin.
// ----------------------------------------------------------------------------
module expression_select_with_dwell import esd_pkg::*; #(
    parameter int NUM_PROTOTYPES = DEF_NUM_PROTOTYPES,
    parameter int AXIS_FRAC_BITS = DEF_AXIS_FRAC_BITS,
    parameter int TIME_BITS      = DEF_TIME_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDXW-1:0]   cfg_index,
    input  logic [CFG_DATAW-1:0]  cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_mode,
    input  logic signed [15:0]    s_valence_in,
    input  logic signed [15:0]    s_arousal_in,
    input  logic signed [15:0]    s_dominance_in,
    input  logic signed [15:0]    s_certainty_in,
    input  logic signed [15:0]    s_warmth_in,
    input  logic signed [15:0]    s_surprise_in,
    input  logic [15:0]           s_response_fraction,
    input  logic [3:0]            s_expression_in,
    input  logic [31:0]           s_time_ms,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [3:0]            m_expression_out,
    output logic signed [15:0]    m_valence_out,
    output logic signed [15:0]    m_arousal_out,
    output logic signed [15:0]    m_dominance_out,
    output logic signed [15:0]    m_certainty_out,
    output logic signed [15:0]    m_warmth_out,
    output logic signed [15:0]    m_surprise_out
);

    esd_cmd_t              cmd;
    esd_status_t           status;
    logic signed [AXW-1:0] axis_in  [AXES];
    logic signed [AXW-1:0] axis_out [AXES];

    assign cfg_ready = 1'b1;

    // Axis bundles
    assign axis_in[0] = s_valence_in;
    assign axis_in[1] = s_arousal_in;
    assign axis_in[2] = s_dominance_in;
    assign axis_in[3] = s_certainty_in;
    assign axis_in[4] = s_warmth_in;
    assign axis_in[5] = s_surprise_in;

    assign m_valence_out   = axis_out[0];
    assign m_arousal_out   = axis_out[1];
    assign m_dominance_out = axis_out[2];
    assign m_certainty_out = axis_out[3];
    assign m_warmth_out    = axis_out[4];
    assign m_surprise_out  = axis_out[5];

    esd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_mode),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    esd_datapath #(
        .NUM_PROTOTYPES (NUM_PROTOTYPES),
        .AXIS_FRAC_BITS (AXIS_FRAC_BITS),
        .TIME_BITS      (TIME_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_mode        (s_mode),
        .axis_in        (axis_in),
        .in_fraction    (s_response_fraction),
        .in_expression  (s_expression_in),
        .in_time        (s_time_ms),
        .out_expression (m_expression_out),
        .axis_out       (axis_out)
    );

endmodule

### tb/expression_select_with_dwell_tb.sv
// ----------------------------------------------------------------------------
// expression_select_with_dwell_tb: self-checking bench for the expression selector
// Drives tick and perform requests through the valid/ready input and checks
// every result against a cycle-free model of the blend, the nearest-prototype
// search and the dwell/margin switch. It runs a directed table, then random
// traffic in four handshake phases, with the configuration changed between them.
// ----------------------------------------------------------------------------
module expression_select_with_dwell_tb;
    import esd_pkg::*;

    localparam int          CYCLE_LIMIT   = 2000000;
    localparam int          RANDOM_ITEMS  = 420;
    localparam int          LONG_HOLD     = 400;
    localparam logic [7:0]  CFG_UNMAPPED  = 8'd9;
    localparam logic        MODE_TICK     = 1'b0;
    localparam logic        MODE_PERFORM  = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [5:0][15:0] ax;
        logic [15:0]      frac;
        logic [3:0]       expr;
        logic [31:0]      now;
    } request_t;

    typedef struct packed {
        logic [3:0]       expr;
        logic [5:0][15:0] ax;
    } affect_t;

    typedef struct packed {
        request_t rq;
        logic     typed;
        affect_t  want;
    } dir_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDXW-1:0]  cfg_index = '0;
    logic [CFG_DATAW-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_mode = 1'b0;
    logic signed [15:0] s_valence_in = '0, s_arousal_in = '0, s_dominance_in = '0;
    logic signed [15:0] s_certainty_in = '0, s_warmth_in = '0, s_surprise_in = '0;
    logic [15:0] s_response_fraction = '0;
    logic [3:0]  s_expression_in = '0;
    logic [31:0] s_time_ms = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [3:0] m_expression_out;
    logic signed [15:0] m_valence_out, m_arousal_out, m_dominance_out;
    logic signed [15:0] m_certainty_out, m_warmth_out, m_surprise_out;

    expression_select_with_dwell u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_valence_in(s_valence_in), .s_arousal_in(s_arousal_in),
        .s_dominance_in(s_dominance_in), .s_certainty_in(s_certainty_in),
        .s_warmth_in(s_warmth_in), .s_surprise_in(s_surprise_in),
        .s_response_fraction(s_response_fraction),
        .s_expression_in(s_expression_in), .s_time_ms(s_time_ms),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_expression_out(m_expression_out),
        .m_valence_out(m_valence_out), .m_arousal_out(m_arousal_out),
        .m_dominance_out(m_dominance_out), .m_certainty_out(m_certainty_out),
        .m_warmth_out(m_warmth_out), .m_surprise_out(m_surprise_out)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Model state
    int          mood [AXES];
    logic [3:0]  shown_expr;
    logic [3:0]  cand_expr;
    logic [31:0] cand_since;
    logic [15:0] dwell_cfg;
    logic [15:0] margin_cfg;

    affect_t     pending_affect [$];
    int          mismatches = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          hold_req = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          cycles = 0;
    logic [31:0] wall_ms = '0;

    // Prototype hundredths to axis units, half away from zero
    function automatic int proto_axis(input int h);
        longint mag;
        longint v;
        mag = (h < 0) ? -longint'(h) : longint'(h);
        v = (mag * (longint'(1) << DEF_AXIS_FRAC_BITS) * 2 + 100) / 200;
        return (h < 0) ? int'(-v) : int'(v);
    endfunction

    function automatic longint unsigned weighted_dist(input int idx);
        longint unsigned sum;
        longint d;
        sum = 0;
        for (int a = 0; a < AXES; a++) begin
            d = longint'(mood[a]) - longint'(proto_axis(PROTO_H[idx][a]));
            sum += longint'(d * d) * WEIGHT_H[a];
        end
        return sum;
    endfunction

    // Lowest index wins a tie
    function automatic logic [3:0] nearest_proto();
        int best;
        longint unsigned best_d;
        longint unsigned d;
        best = 0;
        best_d = weighted_dist(0);
        for (int i = 1; i < DEF_NUM_PROTOTYPES && i < TABLE_ROWS; i++) begin
            d = weighted_dist(i);
            if (d < best_d) begin
                best_d = d;
                best = i;
            end
        end
        return 4'(best);
    endfunction

    function automatic void reset_mood();
        for (int a = 0; a < AXES; a++) mood[a] = proto_axis(IDLE_H[a]);
        shown_expr = nearest_proto();
        cand_expr = shown_expr;
        cand_since = '0;
        dwell_cfg = DWELL_RESET;
        margin_cfg = MARGIN_RESET;
    endfunction

    // Blend then the dwell-gated switch, or load; returns the reported state
    function automatic affect_t apply_request(input request_t rq);
        affect_t res;
        longint diff;
        logic [3:0] c;
        logic [31:0] elapsed;
        longint unsigned gap;
        if (rq.mode == MODE_PERFORM) begin
            if (rq.expr < DEF_NUM_PROTOTYPES && rq.expr < TABLE_ROWS) begin
                for (int a = 0; a < AXES; a++) mood[a] = int'($signed(rq.ax[a]));
                shown_expr = rq.expr;
                cand_expr = rq.expr;
                cand_since = rq.now;
            end
        end else begin
            for (int a = 0; a < AXES; a++) begin
                diff = longint'($signed(rq.ax[a])) - longint'(mood[a]);
                mood[a] = mood[a] + int'((diff * longint'(rq.frac) + 32768) >>> 16);
            end
            c = nearest_proto();
            if (c != cand_expr) begin
                cand_expr = c;
                cand_since = rq.now;
            end
            elapsed = rq.now - cand_since;
            if (c != shown_expr && elapsed >= 32'(dwell_cfg)) begin
                gap = longint'(margin_cfg) * 100 * (longint'(1) << DEF_AXIS_FRAC_BITS);
                if (weighted_dist(c) + gap < weighted_dist(shown_expr)) shown_expr = c;
            end
        end
        res.expr = shown_expr;
        for (int a = 0; a < AXES; a++) res.ax[a] = mood[a][15:0];
        return res;
    endfunction

    function automatic request_t rq_all(input logic m, input logic [15:0] v,
                                        input logic [15:0] f, input logic [3:0] e,
                                        input logic [31:0] t);
        request_t rq;
        rq.mode = m;
        for (int a = 0; a < AXES; a++) rq.ax[a] = v;
        rq.frac = f;
        rq.expr = e;
        rq.now = t;
        return rq;
    endfunction

    function automatic request_t rq_proto(input logic m, input int p,
                                          input logic [15:0] f, input logic [3:0] e,
                                          input logic [31:0] t);
        request_t rq;
        rq = rq_all(m, '0, f, e, t);
        for (int a = 0; a < AXES; a++) rq.ax[a] = 16'(proto_axis(PROTO_H[p][a]));
        return rq;
    endfunction

    function automatic affect_t aff_all(input logic [3:0] e, input logic [15:0] v);
        affect_t r;
        r.expr = e;
        for (int a = 0; a < AXES; a++) r.ax[a] = v;
        return r;
    endfunction

    // Random request: mostly ticks toward a jittered prototype
    function automatic request_t random_request();
        request_t rq;
        int k;
        int p;
        k = $urandom_range(99);
        if ($urandom_range(99) < 3) wall_ms = $urandom;
        else wall_ms = wall_ms + $urandom_range(0, 300);
        p = $urandom_range(TABLE_ROWS - 1);
        rq = rq_all(MODE_TICK, '0, 16'($urandom), 4'($urandom_range(15)), wall_ms);
        rq.mode = (k < 12) ? MODE_PERFORM : MODE_TICK;
        if (k < 10) rq.expr = 4'($urandom_range(TABLE_ROWS - 1));
        k = $urandom_range(99);
        for (int a = 0; a < AXES; a++) begin
            if (k < 70)
                rq.ax[a] = 16'(proto_axis(PROTO_H[p][a]) + $urandom_range(0, 4000) - 2000);
            else if (k < 85)
                rq.ax[a] = 16'(int'($urandom_range(0, 32768)) - 16384);
            else
                rq.ax[a] = 16'($urandom);
        end
        k = $urandom_range(99);
        if (k < 30) rq.frac = 16'hFFFF;
        else if (k < 38) rq.frac = '0;
        return rq;
    endfunction

    // Offer one request, wait for it to be taken, record its expected result
    task automatic send_request(input request_t rq, input logic typed, input affect_t want);
        affect_t exp_res;
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= rq.mode;
        s_valence_in <= rq.ax[0];
        s_arousal_in <= rq.ax[1];
        s_dominance_in <= rq.ax[2];
        s_certainty_in <= rq.ax[3];
        s_warmth_in <= rq.ax[4];
        s_surprise_in <= rq.ax[5];
        s_response_fraction <= rq.frac;
        s_expression_in <= rq.expr;
        s_time_ms <= rq.now;
        do @(posedge aclk); while (!s_ready);
        exp_res = apply_request(rq);
        pending_affect.push_back(typed ? want : exp_res);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_affect.size() != 0) @(posedge aclk);
    endtask

    // One register write; cfg_valid is dropped between writes to keep them apart
    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_DWELL) dwell_cfg = val;
        else if (idx == CFG_MARGIN) margin_cfg = val;
        @(posedge aclk);
    endtask

    // Receiver: random stalls plus an occasional long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= LONG_HOLD;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Result checker
    always @(posedge aclk) begin
        affect_t got;
        affect_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            got.expr = m_expression_out;
            got.ax = {m_surprise_out, m_warmth_out, m_certainty_out,
                      m_dominance_out, m_arousal_out, m_valence_out};
            if (pending_affect.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result: %h", got);
            end else begin
                exp_res = pending_affect.pop_front();
                if (got !== exp_res) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expr exp %0d got %0d", exp_res.expr, got.expr);
                        for (int a = 0; a < AXES; a++)
                            $display("  axis %0d exp %0d got %0d", a,
                                     $signed(exp_res.ax[a]), $signed(got.ax[a]));
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("expression_select_with_dwell_tb failed");
            $finish;
        end
    end

    dir_row_t rows [$];
    dir_row_t row;
    request_t mid;

    initial begin
        reset_mood();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table; typed expectations for loads and ignored loads
        rows.push_back('{rq_all(MODE_TICK, 16'd0, 16'd0, 4'd0, 32'd0), 1'b0, '0});
        rows.push_back('{rq_all(MODE_PERFORM, 16'sd16384, 16'd0, 4'd9, 32'd100), 1'b1,
                         aff_all(4'd9, 16'sd16384)});
        rows.push_back('{rq_all(MODE_PERFORM, -16'sd16384, 16'hFFFF, 4'd0, 32'd200), 1'b1,
                         aff_all(4'd0, -16'sd16384)});
        rows.push_back('{rq_all(MODE_PERFORM, 16'sd5, 16'd0, 4'd15, 32'd300), 1'b1,
                         aff_all(4'd0, -16'sd16384)});
        rows.push_back('{rq_all(MODE_PERFORM, 16'sd5, 16'd0, 4'd10, 32'd300), 1'b1,
                         aff_all(4'd0, -16'sd16384)});
        rows.push_back('{rq_all(MODE_PERFORM, 16'h7FFF, 16'd0, 4'd3, 32'hFFFF_FFFF), 1'b1,
                         aff_all(4'd3, 16'h7FFF)});
        rows.push_back('{rq_all(MODE_PERFORM, 16'h8000, 16'd0, 4'd4, 32'd0), 1'b1,
                         aff_all(4'd4, 16'h8000)});
        rows.push_back('{rq_all(MODE_TICK, 16'h7FFF, 16'hFFFF, 4'd0, 32'd10), 1'b0, '0});
        rows.push_back('{rq_all(MODE_TICK, 16'sd16384, 16'h8000, 4'hF, 32'd20), 1'b0, '0});
        // Dwell: load prototype 0, then move onto prototype 1
        rows.push_back('{rq_proto(MODE_PERFORM, 0, 16'd0, 4'd0, 32'd1000), 1'b0, '0});
        rows.push_back('{rq_proto(MODE_TICK, 1, 16'hFFFF, 4'd0, 32'd1000), 1'b0, '0});
        rows.push_back('{rq_proto(MODE_TICK, 1, 16'hFFFF, 4'd0, 32'd1649), 1'b0, '0});
        rows.push_back('{rq_proto(MODE_TICK, 1, 16'hFFFF, 4'd0, 32'd1650), 1'b0, '0});
        // Dwell across the time wrap
        rows.push_back('{rq_proto(MODE_PERFORM, 5, 16'd0, 4'd5, 32'hFFFF_FF00), 1'b0, '0});
        rows.push_back('{rq_proto(MODE_TICK, 7, 16'hFFFF, 4'd0, 32'hFFFF_FF80), 1'b0, '0});
        rows.push_back('{rq_proto(MODE_TICK, 7, 16'hFFFF, 4'd0, 32'h0000_0100), 1'b0, '0});
        rows.push_back('{rq_proto(MODE_TICK, 7, 16'hFFFF, 4'd0, 32'h0000_0300), 1'b0, '0});
        // Midpoint of two close prototypes, a likely tie
        mid = rq_all(MODE_PERFORM, '0, 16'd0, 4'd9, 32'd5000);
        for (int a = 0; a < AXES; a++)
            mid.ax[a] = 16'((proto_axis(PROTO_H[0][a]) + proto_axis(PROTO_H[2][a])) / 2);
        rows.push_back('{mid, 1'b0, '0});
        rows.push_back('{rq_all(MODE_TICK, 16'd0, 16'd0, 4'd0, 32'd9000), 1'b0, '0});
        rows.push_back('{rq_all(MODE_TICK, -16'sd16384, 16'd1, 4'd0, 32'd9100), 1'b0, '0});

        foreach (rows[i]) begin
            row = rows[i];
            send_request(row.rq, row.typed, row.want);
        end
        drain_results();

        // Random phases, configuration rewritten while idle
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    idle_pct = 0;   stall_pct = 0;
                    write_reg(CFG_DWELL, 16'd650);
                    write_reg(CFG_MARGIN, 16'd1638);
                    write_reg(CFG_UNMAPPED, 16'hFFFF);
                end
                1: begin
                    idle_pct = 46;  stall_pct = 0;
                    write_reg(CFG_DWELL, 16'd0);
                    write_reg(CFG_MARGIN, 16'd0);
                end
                2: begin
                    idle_pct = 0;   stall_pct = 46;
                    write_reg(CFG_DWELL, 16'hFFFF);
                    write_reg(CFG_MARGIN, 16'hFFFF);
                end
                default: begin
                    idle_pct = 29;  stall_pct = 29;
                    write_reg(CFG_DWELL, 16'($urandom_range(1, 1200)));
                    write_reg(CFG_MARGIN, 16'($urandom_range(1, 4000)));
                end
            endcase
            for (int n = 0; n < RANDOM_ITEMS; n++) begin
                if (n == 60) hold_req++;
                if (n == 200) drain_results();
                send_request(random_request(), 1'b0, '0);
            end
            drain_results();
        end

        repeat (100) @(posedge aclk);
        if (mismatches == 0 && pending_affect.size() == 0) begin
            $display("expression_select_with_dwell_tb passed");
        end else begin
            $display("expression_select_with_dwell_tb failed");
        end
        $finish;
    end

endmodule

### expression_select_with_dwell.f
hdl/esd_pkg.sv
hdl/esd_datapath.sv
hdl/esd_ctrl.sv
hdl/expression_select_with_dwell.sv
tb/expression_select_with_dwell_tb.sv
